// File: src/ac_rms_pkg.sv
`default_nettype none
package ac_rms_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int MEAN_SHIFT     = 10;
   localparam int WINDOW_SAMPLES = 4096;

   localparam int IN_W     = 16;
   localparam int OUT_W    = 17;
   localparam int NUM_CHAN = 6;

   localparam int EXT_W     = (SAMPLE_BITS > IN_W) ? SAMPLE_BITS : IN_W;
   localparam int MEAN_W    = SAMPLE_BITS + MEAN_SHIFT;
   localparam int DIFF_W    = MEAN_W + 1;
   localparam int AC_W      = SAMPLE_BITS + 1;
   localparam int SQ_W      = 2 * SAMPLE_BITS;
   localparam int CNT_W     = $clog2(WINDOW_SAMPLES + 1);
   localparam int LOG2W     = CNT_W - 1;
   localparam int ENERGY_W  = SQ_W + CNT_W;
   localparam int SHIFTED_W = ENERGY_W - LOG2W;
   localparam int ROOT_W    = (SHIFTED_W + 1) / 2;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int REM_W     = ROOT_W + 2;
   localparam int STEP_W    = $clog2(ROOT_W);

   typedef struct packed {
      logic cap;
      logic mean_en;
      logic ac_en;
      logic sq_en;
      logic acc_en;
      logic sqrt_load;
      logic sqrt_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last_item;
   } status_type;

endpackage
`default_nettype wire

// File: src/ac_rms_ctrl.sv
`default_nettype none
module ac_rms_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire ac_rms_pkg::status_type  status,
   output ac_rms_pkg::cmd_type          cmd
);
   import ac_rms_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MEAN   = 8'b0000_0010,
      ST_AC     = 8'b0000_0100,
      ST_SQ     = 8'b0000_1000,
      ST_ACC    = 8'b0001_0000,
      ST_SQLOAD = 8'b0010_0000,
      ST_SQRT   = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              take;

   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_ACC) && !status.last_item));
   assign take      = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.cap      = take;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            cmd.mean_en = 1'b1;
            state_in    = ST_AC;
         end
         ST_AC: begin
            cmd.ac_en = 1'b1;
            state_in  = ST_SQ;
         end
         ST_SQ: begin
            cmd.sq_en = 1'b1;
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            priority if (status.last_item) begin
               state_in = ST_SQLOAD;
            end else if (take) begin
               state_in = ST_MEAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SQLOAD: begin
            cmd.sqrt_load = 1'b1;
            step_in       = '0;
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: src/ac_rms_dp.sv
`default_nettype none
module ac_rms_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire ac_rms_pkg::cmd_type                   cmd,
   output ac_rms_pkg::status_type                     status,
   input  wire logic signed [ac_rms_pkg::IN_W-1:0]    req_raw_x,
   input  wire logic signed [ac_rms_pkg::IN_W-1:0]    req_raw_y,
   input  wire logic signed [ac_rms_pkg::IN_W-1:0]    req_raw_z,
   input  wire logic signed [ac_rms_pkg::IN_W-1:0]    req_filt_x,
   input  wire logic signed [ac_rms_pkg::IN_W-1:0]    req_filt_y,
   input  wire logic signed [ac_rms_pkg::IN_W-1:0]    req_filt_z,
   output logic [ac_rms_pkg::OUT_W-1:0]               rsp_raw_rms_x,
   output logic [ac_rms_pkg::OUT_W-1:0]               rsp_raw_rms_y,
   output logic [ac_rms_pkg::OUT_W-1:0]               rsp_raw_rms_z,
   output logic [ac_rms_pkg::OUT_W-1:0]               rsp_filt_rms_x,
   output logic [ac_rms_pkg::OUT_W-1:0]               rsp_filt_rms_y,
   output logic [ac_rms_pkg::OUT_W-1:0]               rsp_filt_rms_z
);
   import ac_rms_pkg::*;

   logic signed [SAMPLE_BITS-1:0] samp_in   [NUM_CHAN];
   logic signed [SAMPLE_BITS-1:0] samp_ff   [NUM_CHAN];
   logic signed [MEAN_W-1:0]      target    [NUM_CHAN];
   logic signed [DIFF_W-1:0]      diff      [NUM_CHAN];
   logic signed [DIFF_W-1:0]      step      [NUM_CHAN];
   logic signed [MEAN_W-1:0]      mean_in   [NUM_CHAN];
   logic signed [MEAN_W-1:0]      mean_ff   [NUM_CHAN];
   logic signed [MEAN_W-1:0]      mean_fl   [NUM_CHAN];
   logic signed [AC_W-1:0]        ac_in     [NUM_CHAN];
   logic signed [AC_W-1:0]        ac_ff     [NUM_CHAN];
   logic signed [2*AC_W-1:0]      prod      [NUM_CHAN];
   logic [SQ_W-1:0]               sq_ff     [NUM_CHAN];
   logic [ENERGY_W-1:0]           energy_ff [NUM_CHAN];
   logic [RAD_W-1:0]              rad_ff    [NUM_CHAN];
   logic [REM_W-1:0]              rem_ff    [NUM_CHAN];
   logic [REM_W-1:0]              rem_in    [NUM_CHAN];
   logic [ROOT_W-1:0]             root_ff   [NUM_CHAN];
   logic [ROOT_W-1:0]             root_in   [NUM_CHAN];
   logic [REM_W+1:0]              cand      [NUM_CHAN];
   logic [REM_W+1:0]              trial     [NUM_CHAN];
   logic [OUT_W-1:0]              rms_ff    [NUM_CHAN];
   logic [CNT_W-1:0]              cnt_ff;
   logic                          seeded_ff;

   function automatic logic signed [SAMPLE_BITS-1:0] sext_in(input logic [IN_W-1:0] v);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(v);
      return signed'(ext[SAMPLE_BITS-1:0]);
   endfunction

   assign samp_in[0] = sext_in(req_raw_x);
   assign samp_in[1] = sext_in(req_raw_y);
   assign samp_in[2] = sext_in(req_raw_z);
   assign samp_in[3] = sext_in(req_filt_x);
   assign samp_in[4] = sext_in(req_filt_y);
   assign samp_in[5] = sext_in(req_filt_z);

   assign status.last_item = (cnt_ff == CNT_W'(WINDOW_SAMPLES - 1));

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         target[c]  = signed'({samp_ff[c], {MEAN_SHIFT{1'b0}}});
         diff[c]    = DIFF_W'(target[c]) - DIFF_W'(mean_ff[c]);
         step[c]    = diff[c] >>> MEAN_SHIFT;
         mean_in[c] = seeded_ff ? (mean_ff[c] + MEAN_W'(step[c])) : target[c];
         mean_fl[c] = mean_ff[c] >>> MEAN_SHIFT;
         ac_in[c]   = AC_W'(samp_ff[c]) - AC_W'(mean_fl[c]);
         prod[c]    = ac_ff[c] * ac_ff[c];
         cand[c]    = {rem_ff[c], rad_ff[c][RAD_W-1 -: 2]};
         trial[c]   = (REM_W + 2)'({root_ff[c], 2'b01});
         if (cand[c] >= trial[c]) begin
            rem_in[c]  = REM_W'(cand[c] - trial[c]);
            root_in[c] = {root_ff[c][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[c]  = REM_W'(cand[c]);
            root_in[c] = {root_ff[c][ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 1'b0;
         cnt_ff    <= '0;
         for (int c = 0; c < NUM_CHAN; c++) begin
            mean_ff[c]   <= '0;
            energy_ff[c] <= '0;
         end
      end else begin
         if (cmd.mean_en) begin
            seeded_ff <= 1'b1;
            for (int c = 0; c < NUM_CHAN; c++) begin
               mean_ff[c] <= mean_in[c];
            end
         end
         if (cmd.acc_en) begin
            cnt_ff <= cnt_ff + 1'b1;
            for (int c = 0; c < NUM_CHAN; c++) begin
               energy_ff[c] <= energy_ff[c] + ENERGY_W'(sq_ff[c]);
            end
         end
         if (cmd.sqrt_load) begin
            cnt_ff <= '0;
            for (int c = 0; c < NUM_CHAN; c++) begin
               energy_ff[c] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (cmd.cap) begin
            samp_ff[c] <= samp_in[c];
         end
         if (cmd.ac_en) begin
            ac_ff[c] <= ac_in[c];
         end
         if (cmd.sq_en) begin
            sq_ff[c] <= prod[c][SQ_W-1:0];
         end
         if (cmd.sqrt_load) begin
            rad_ff[c]  <= RAD_W'(energy_ff[c] >> LOG2W);
            rem_ff[c]  <= '0;
            root_ff[c] <= '0;
         end else if (cmd.sqrt_step) begin
            rad_ff[c]  <= rad_ff[c] << 2;
            rem_ff[c]  <= rem_in[c];
            root_ff[c] <= root_in[c];
         end
         if (cmd.out_load) begin
            rms_ff[c] <= OUT_W'(root_ff[c]);
         end
      end
   end

   assign rsp_raw_rms_x  = rms_ff[0];
   assign rsp_raw_rms_y  = rms_ff[1];
   assign rsp_raw_rms_z  = rms_ff[2];
   assign rsp_filt_rms_x = rms_ff[3];
   assign rsp_filt_rms_y = rms_ff[4];
   assign rsp_filt_rms_z = rms_ff[5];

endmodule
`default_nettype wire

// File: src/ac_rms_vibration_monitor_core.sv
// AC RMS monitor for a raw and a filtered three-axis stream. Each accepted beat passes through
// four lane stages (mean update, AC value, square, energy accumulate) on all six channels at
// once, and a new beat is taken in the accumulate cycle, so the next beat can enter while the
// previous one accumulates. The beat that closes a window of 4096 is followed by a bit-serial
// square root in each channel, one result bit per cycle for a 17-bit root, and no beat is
// taken until the root is loaded into the output register. The result sits there while the
// next window runs; a second result waits only if the first has still not been taken. The
// first beat after reset seeds the DC means.
`default_nettype none
module ac_rms_vibration_monitor_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [ac_rms_pkg::IN_W-1:0]    req_raw_x,
   input  wire logic signed [ac_rms_pkg::IN_W-1:0]    req_raw_y,
   input  wire logic signed [ac_rms_pkg::IN_W-1:0]    req_raw_z,
   input  wire logic signed [ac_rms_pkg::IN_W-1:0]    req_filt_x,
   input  wire logic signed [ac_rms_pkg::IN_W-1:0]    req_filt_y,
   input  wire logic signed [ac_rms_pkg::IN_W-1:0]    req_filt_z,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [ac_rms_pkg::OUT_W-1:0]               rsp_raw_rms_x,
   output logic [ac_rms_pkg::OUT_W-1:0]               rsp_raw_rms_y,
   output logic [ac_rms_pkg::OUT_W-1:0]               rsp_raw_rms_z,
   output logic [ac_rms_pkg::OUT_W-1:0]               rsp_filt_rms_x,
   output logic [ac_rms_pkg::OUT_W-1:0]               rsp_filt_rms_y,
   output logic [ac_rms_pkg::OUT_W-1:0]               rsp_filt_rms_z
);
   import ac_rms_pkg::*;

   cmd_type    cmd;
   status_type status;

   ac_rms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ac_rms_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_raw_x      (req_raw_x),
      .req_raw_y      (req_raw_y),
      .req_raw_z      (req_raw_z),
      .req_filt_x     (req_filt_x),
      .req_filt_y     (req_filt_y),
      .req_filt_z     (req_filt_z),
      .rsp_raw_rms_x  (rsp_raw_rms_x),
      .rsp_raw_rms_y  (rsp_raw_rms_y),
      .rsp_raw_rms_z  (rsp_raw_rms_z),
      .rsp_filt_rms_x (rsp_filt_rms_x),
      .rsp_filt_rms_y (rsp_filt_rms_y),
      .rsp_filt_rms_z (rsp_filt_rms_z)
   );

endmodule
`default_nettype wire

// File: src/ac_rms_chk.sv
`default_nettype none
module ac_rms_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [16:0] rsp_raw_rms_x,
   input wire logic [16:0] rsp_raw_rms_y,
   input wire logic [16:0] rsp_raw_rms_z,
   input wire logic [16:0] rsp_filt_rms_x,
   input wire logic [16:0] rsp_filt_rms_y,
   input wire logic [16:0] rsp_filt_rms_z
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken in the cycle after a beat");

   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a busy cycle before it");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_raw_rms_x)
         && $stable(rsp_raw_rms_y) && $stable(rsp_raw_rms_z) && $stable(rsp_filt_rms_x)
         && $stable(rsp_filt_rms_y) && $stable(rsp_filt_rms_z)))
      else $error("stalled result changed");

endmodule

bind ac_rms_vibration_monitor_core ac_rms_chk u_chk (.*);
`default_nettype wire

// File: sim/tb_ac_rms_vibration_monitor_core.sv
`timescale 1ns / 100ps
module tb_ac_rms_vibration_monitor_core;
   import ac_rms_pkg::*;

   localparam int WINDOWS_TARGET = 36;
   localparam int TAIL_BEATS     = 1500;
   localparam int CALM_BEATS     = 6000;
   localparam int SEGMENT_BEATS  = 256;
   localparam int RSP_LONG_HOLD  = 45000;
   localparam int DRAIN_CYCLES   = 64;
   localparam int DIR_ROWS       = 12;

   typedef logic [NUM_CHAN-1:0][IN_W-1:0]  beat_vec_t;
   typedef logic [NUM_CHAN-1:0][OUT_W-1:0] rms_vec_t;

   typedef enum logic {ROW_HOLD, ROW_TOGGLE} row_mode_e;
   typedef enum logic [1:0] {WAVE_FULL, WAVE_DC_NOISE, WAVE_RAIL} wave_e;

   typedef struct {
      int unsigned count;
      row_mode_e   mode;
      beat_vec_t   smp;
      bit          typed;
      rms_vec_t    rms;
   } dir_row_t;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [IN_W-1:0] req_raw_x, req_raw_y, req_raw_z;
   logic signed [IN_W-1:0] req_filt_x, req_filt_y, req_filt_z;
   logic rsp_valid;
   logic rsp_stall;
   logic [OUT_W-1:0] rsp_raw_rms_x, rsp_raw_rms_y, rsp_raw_rms_z;
   logic [OUT_W-1:0] rsp_filt_rms_x, rsp_filt_rms_y, rsp_filt_rms_z;

   longint      dc_mean [NUM_CHAN] = '{default: 0};
   logic [63:0] ac_energy [NUM_CHAN] = '{default: '0};
   int unsigned window_fill = 0;
   bit          dc_seeded = 1'b0;

   rms_vec_t    rms_expect_q[$];
   int          mismatch_count = 0;
   int          windows_checked = 0;
   int unsigned beats_sent = 0;
   bit          calm = 1'b0;
   bit          rsp_hold_req = 1'b0;

   string chan_name [NUM_CHAN] = '{"raw_x", "raw_y", "raw_z", "filt_x", "filt_y", "filt_z"};

   ac_rms_vibration_monitor_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_raw_x      (req_raw_x),
      .req_raw_y      (req_raw_y),
      .req_raw_z      (req_raw_z),
      .req_filt_x     (req_filt_x),
      .req_filt_y     (req_filt_y),
      .req_filt_z     (req_filt_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_raw_rms_x  (rsp_raw_rms_x),
      .rsp_raw_rms_y  (rsp_raw_rms_y),
      .rsp_raw_rms_z  (rsp_raw_rms_z),
      .rsp_filt_rms_x (rsp_filt_rms_x),
      .rsp_filt_rms_y (rsp_filt_rms_y),
      .rsp_filt_rms_z (rsp_filt_rms_z)
   );

   always #4 clock = ~clock;

   function automatic logic [31:0] floor_root(input logic [63:0] v);
      logic [31:0] r;
      logic [31:0] t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (32'd1 << b);
         if (64'(t) * 64'(t) <= v) r = t;
      end
      return r;
   endfunction

   function automatic bit absorb_beat(input beat_vec_t smp, output rms_vec_t rms);
      longint      s;
      longint      ac;
      logic [63:0] mag;
      rms = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         s = longint'($signed(smp[c]));
         if (!dc_seeded) dc_mean[c] = s <<< MEAN_SHIFT;
         dc_mean[c] += ((s <<< MEAN_SHIFT) - dc_mean[c]) >>> MEAN_SHIFT;
         ac = s - (dc_mean[c] >>> MEAN_SHIFT);
         mag = (ac < 0) ? 64'(-ac) : 64'(ac);
         ac_energy[c] += mag * mag;
      end
      dc_seeded = 1'b1;
      window_fill++;
      if (window_fill < WINDOW_SAMPLES) return 1'b0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         rms[c] = OUT_W'(floor_root(ac_energy[c] >> LOG2W));
         ac_energy[c] = '0;
      end
      window_fill = 0;
      return 1'b1;
   endfunction

   task automatic offer_beat(input beat_vec_t smp, input bit typed, input rms_vec_t typed_rms);
      rms_vec_t rms;
      if (!calm && $urandom_range(0, 31) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_raw_x  <= smp[0];
      req_raw_y  <= smp[1];
      req_raw_z  <= smp[2];
      req_filt_x <= smp[3];
      req_filt_y <= smp[4];
      req_filt_z <= smp[5];
      do @(posedge clock); while (req_stall);
      if (absorb_beat(smp, rms)) rms_expect_q.push_back(typed ? typed_rms : rms);
      beats_sent++;
   endtask

   initial begin
      dir_row_t    dir_rows [DIR_ROWS];
      rms_vec_t    no_rms;
      beat_vec_t   smp;
      wave_e       wave [NUM_CHAN];
      int          dc [NUM_CHAN];
      int          amp [NUM_CHAN];
      int          v;
      int unsigned directed_total;
      int unsigned random_beats;
      bit          paused;

      no_rms = '0;
      paused = 1'b0;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_raw_x  <= '0;
      req_raw_y  <= '0;
      req_raw_z  <= '0;
      req_filt_x <= '0;
      req_filt_y <= '0;
      req_filt_z <= '0;

      dir_rows[0]  = '{4096, ROW_HOLD,   {NUM_CHAN{16'h8000}}, 1'b1, '0};
      dir_rows[1]  = '{4096, ROW_TOGGLE, {NUM_CHAN{16'h8000}}, 1'b0, '0};
      dir_rows[2]  = '{3,    ROW_HOLD,   {NUM_CHAN{16'h7FFF}}, 1'b0, '0};
      dir_rows[3]  = '{3,    ROW_HOLD,   {NUM_CHAN{16'h0000}}, 1'b0, '0};
      dir_rows[4]  = '{2,    ROW_HOLD,   {NUM_CHAN{16'hFFFF}}, 1'b0, '0};
      dir_rows[5]  = '{2,    ROW_HOLD,   {NUM_CHAN{16'h0001}}, 1'b0, '0};
      dir_rows[6]  = '{4,    ROW_TOGGLE, {NUM_CHAN{16'h5555}}, 1'b0, '0};
      dir_rows[7]  = '{4,    ROW_TOGGLE, {NUM_CHAN{16'h3333}}, 1'b0, '0};
      dir_rows[8]  = '{4,    ROW_TOGGLE, {NUM_CHAN{16'h0F0F}}, 1'b0, '0};
      dir_rows[9]  = '{4,    ROW_TOGGLE, {NUM_CHAN{16'h00FF}}, 1'b0, '0};
      dir_rows[10] = '{3, ROW_HOLD,
                       {16'hEDCB, 16'h1234, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF}, 1'b0, '0};
      dir_rows[11] = '{2, ROW_TOGGLE,
                       {16'h8001, 16'h7FFE, 16'h4000, 16'hC000, 16'h0001, 16'hFFFE}, 1'b0, '0};

      directed_total = 0;
      foreach (dir_rows[i]) directed_total += dir_rows[i].count;
      random_beats = WINDOWS_TARGET * WINDOW_SAMPLES + TAIL_BEATS - directed_total;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         for (int unsigned k = 0; k < dir_rows[i].count; k++) begin
            smp = (dir_rows[i].mode == ROW_TOGGLE && k[0]) ? ~dir_rows[i].smp : dir_rows[i].smp;
            offer_beat(smp, dir_rows[i].typed && k == dir_rows[i].count - 1, dir_rows[i].rms);
         end
      end

      for (int unsigned n = 0; n < random_beats; n++) begin
         calm = (random_beats - n < CALM_BEATS);
         if (n == 2 * WINDOW_SAMPLES + 17) rsp_hold_req = 1'b1;
         if (n % SEGMENT_BEATS == 0) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
               wave[c] = wave_e'($urandom_range(0, 2));
               dc[c]   = int'($urandom_range(0, 65535)) - 32768;
               amp[c]  = 1 << $urandom_range(0, 15);
            end
         end
         for (int c = 0; c < NUM_CHAN; c++) begin
            case (wave[c])
               WAVE_FULL: begin
                  smp[c] = IN_W'($urandom);
               end
               WAVE_DC_NOISE: begin
                  v = dc[c] + int'($urandom_range(0, 2 * amp[c])) - amp[c];
                  if (v > 32767) v = 32767;
                  if (v < -32768) v = -32768;
                  smp[c] = IN_W'(v);
               end
               default: begin
                  v = $urandom_range(0, 2);
                  smp[c] = (v == 0) ? {1'b0, {(IN_W-1){1'b1}}} :
                           (v == 1) ? {1'b1, {(IN_W-1){1'b0}}} : IN_W'(dc[c]);
               end
            endcase
         end
         offer_beat(smp, 1'b0, no_rms);
         if (!paused && n > 5 * WINDOW_SAMPLES && rms_expect_q.size() != 0) begin
            // hold the input until the window result drains
            req_valid <= 1'b0;
            while (rms_expect_q.size() != 0) @(posedge clock);
            paused = 1'b1;
         end
      end

      req_valid <= 1'b0;
      while (rms_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d sample beats (seeded rails, full-swing toggles, DC plus noise)",
               beats_sent);
      $display("summary: %0d RMS windows compared, long output back-pressure and input drain",
               windows_checked);
      if (mismatch_count == 0 && rms_expect_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (RSP_LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rms_vec_t got;
      rms_vec_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_filt_rms_z, rsp_filt_rms_y, rsp_filt_rms_x,
                rsp_raw_rms_z, rsp_raw_rms_y, rsp_raw_rms_x};
         if (rms_expect_q.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected rms beat: raw %0d %0d %0d filt %0d %0d %0d",
                        got[0], got[1], got[2], got[3], got[4], got[5]);
            mismatch_count++;
         end else begin
            want = rms_expect_q.pop_front();
            windows_checked++;
            for (int c = 0; c < NUM_CHAN; c++) begin
               if (got[c] !== want[c]) begin
                  if (mismatch_count < 10)
                     $display("rms mismatch in window %0d on %s: expected %0d, got %0d",
                              windows_checked, chan_name[c], want[c], got[c]);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      #80_000_000;
      $display("run limit reached with %0d windows pending", rms_expect_q.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
